// ===== hdl/escc_pkg.sv =====
// Shared types and fixed field widths for the segment crossing checker.
package escc_pkg;

    localparam int KIND_W      = 3;
    localparam int FIELD_W     = 16;
    localparam int COUNT_OUT_W = 9;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR       = 3'd0,
        KIND_INSERT      = 3'd1,
        KIND_CROSS_ALL   = 3'd2,
        KIND_CROSS_FIRST = 3'd3,
        KIND_POINT       = 3'd4
    } kind_t;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic out_load;
    } escc_cmd_t;

    typedef struct packed {
        logic empty;
        logic addr_last;
        logic pipe_busy;
        logic out_free;
    } escc_stat_t;

endpackage

// ===== hdl/escc_ifs.sv =====
// Valid/ready channel interfaces for query beats and result beats.
interface escc_in_if import escc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic signed [FIELD_W-1:0] ax;
    logic signed [FIELD_W-1:0] ay;
    logic signed [FIELD_W-1:0] bx;
    logic signed [FIELD_W-1:0] by;

    modport source (output valid, kind, ax, ay, bx, by, input ready);
    modport sink   (input valid, kind, ax, ay, bx, by, output ready);
endinterface

interface escc_out_if import escc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   hit;
    logic [COUNT_OUT_W-1:0] stored_count;
    logic                   overflow;

    modport source (output valid, hit, stored_count, overflow, input ready);
    modport sink   (input valid, hit, stored_count, overflow, output ready);
endinterface

// ===== hdl/escc_ctrl.sv =====
// Sequencing state machine: accept, table scan, pipeline drain, result hand-off.
module escc_ctrl import escc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic [KIND_W-1:0] req_kind,
    output logic              req_ready,
    output escc_cmd_t         cmd,
    input  escc_stat_t        stat
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;
    logic   accept;
    logic   is_query;

    assign accept   = req_valid && ready_reg;
    assign is_query = (req_kind == KIND_CROSS_ALL) || (req_kind == KIND_CROSS_FIRST) ||
                      (req_kind == KIND_POINT);

    assign req_ready    = ready_reg;
    assign cmd.load     = accept;
    assign cmd.rd_en    = (state_reg == ST_SCAN);
    assign cmd.out_load = (state_reg == ST_DONE) && stat.out_free;

    always_comb
    begin
        state_next = state_reg;
        ready_next = ready_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ready_next = 1'b0;
                    state_next = (is_query && !stat.empty) ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (stat.addr_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                    ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

endmodule

// ===== hdl/escc_dpath.sv =====
// Segment table, count, intersection pipeline, hit accumulator and result register.
module escc_dpath import escc_pkg::*;
#(
    parameter int MAX_SEGMENTS = 256,
    parameter int COORD_BITS   = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  escc_cmd_t                 cmd,
    output escc_stat_t                stat,
    input  logic [KIND_W-1:0]         in_kind,
    input  logic signed [FIELD_W-1:0] in_ax,
    input  logic signed [FIELD_W-1:0] in_ay,
    input  logic signed [FIELD_W-1:0] in_bx,
    input  logic signed [FIELD_W-1:0] in_by,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      out_hit,
    output logic [COUNT_OUT_W-1:0]    out_count,
    output logic                      out_ovf
);

    localparam int C       = COORD_BITS;
    localparam int D       = COORD_BITS + 1;
    localparam int P       = 2 * D;
    localparam int X       = P + 1;
    localparam int ENTRY_W = 4 * C;
    localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
    localparam int IDX_W   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int RAW_W   = 32;

    logic [ENTRY_W-1:0] mem [MAX_SEGMENTS];

    logic [CNT_W-1:0]  count_reg;
    logic [IDX_W-1:0]  addr_reg;
    logic [KIND_W-1:0] q_kind_reg;
    logic signed [C-1:0] q_ax_reg, q_ay_reg, q_bx_reg, q_by_reg;
    logic              ovf_reg;
    logic              acc_reg;
    logic              full;

    logic [RAW_W-1:0]  raw_ax, raw_ay, raw_bx, raw_by;
    logic signed [C-1:0] c_ax, c_ay, c_bx, c_by;

    assign raw_ax = {{(RAW_W-FIELD_W){1'b0}}, in_ax};
    assign raw_ay = {{(RAW_W-FIELD_W){1'b0}}, in_ay};
    assign raw_bx = {{(RAW_W-FIELD_W){1'b0}}, in_bx};
    assign raw_by = {{(RAW_W-FIELD_W){1'b0}}, in_by};
    assign c_ax   = signed'(raw_ax[C-1:0]);
    assign c_ay   = signed'(raw_ay[C-1:0]);
    assign c_bx   = signed'(raw_bx[C-1:0]);
    assign c_by   = signed'(raw_by[C-1:0]);

    assign full = (count_reg == CNT_W'(MAX_SEGMENTS));

    // count, overflow flag and query capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.load)
        begin
            if (in_kind == KIND_CLEAR)
                count_reg <= '0;
            else if ((in_kind == KIND_INSERT) && !full)
                count_reg <= count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            q_kind_reg <= in_kind;
            q_ax_reg   <= c_ax;
            q_ay_reg   <= c_ay;
            q_bx_reg   <= c_bx;
            q_by_reg   <= c_by;
            ovf_reg    <= (in_kind == KIND_INSERT) && full;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            addr_reg <= '0;
        else if (cmd.rd_en)
            addr_reg <= addr_reg + IDX_W'(1);
    end

    // segment table
    logic [ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load && (in_kind == KIND_INSERT) && !full)
            mem[count_reg[IDX_W-1:0]] <= {c_ax, c_ay, c_bx, c_by};
        if (cmd.rd_en)
            rdata_reg <= mem[addr_reg];
    end

    // stage 1: differences and box tests
    logic signed [C-1:0] s_cx, s_cy, s_dx, s_dy;
    logic box_fail, skip_c, in_box_c;
    logic vr_reg, v1_reg, v2_reg;

    assign s_cx = signed'(rdata_reg[4*C-1:3*C]);
    assign s_cy = signed'(rdata_reg[3*C-1:2*C]);
    assign s_dx = signed'(rdata_reg[2*C-1:C]);
    assign s_dy = signed'(rdata_reg[C-1:0]);

    always_comb
    begin
        box_fail =
            ((q_ax_reg < s_cx) && (q_ax_reg < s_dx) && (q_bx_reg < s_cx) && (q_bx_reg < s_dx)) ||
            ((q_ay_reg < s_cy) && (q_ay_reg < s_dy) && (q_by_reg < s_cy) && (q_by_reg < s_dy)) ||
            ((s_cx < q_ax_reg) && (s_cx < q_bx_reg) && (s_dx < q_ax_reg) && (s_dx < q_bx_reg)) ||
            ((s_cy < q_ay_reg) && (s_cy < q_by_reg) && (s_dy < q_ay_reg) && (s_dy < q_by_reg));
        skip_c =
            ((s_cx == q_ax_reg) && (s_cy == q_ay_reg)) ||
            ((s_dx == q_ax_reg) && (s_dy == q_ay_reg)) ||
            ((q_kind_reg == KIND_CROSS_ALL) &&
             (((s_cx == q_bx_reg) && (s_cy == q_by_reg)) ||
              ((s_dx == q_bx_reg) && (s_dy == q_by_reg))));
        in_box_c =
            ((q_ax_reg >= s_cx) || (q_ax_reg >= s_dx)) &&
            ((q_ax_reg <= s_cx) || (q_ax_reg <= s_dx)) &&
            ((q_ay_reg >= s_cy) || (q_ay_reg >= s_dy)) &&
            ((q_ay_reg <= s_cy) || (q_ay_reg <= s_dy));
    end

    logic signed [D-1:0] d_cax, d_cay, d_dax, d_day, d_bax, d_bay;
    logic signed [D-1:0] d_acx, d_acy, d_dcx, d_dcy, d_bcx, d_bcy;
    logic box1_reg, skip1_reg, inbox1_reg;

    always_ff @(posedge clk)
    begin
        d_cax      <= D'(s_cx) - D'(q_ax_reg);
        d_cay      <= D'(s_cy) - D'(q_ay_reg);
        d_dax      <= D'(s_dx) - D'(q_ax_reg);
        d_day      <= D'(s_dy) - D'(q_ay_reg);
        d_bax      <= D'(q_bx_reg) - D'(q_ax_reg);
        d_bay      <= D'(q_by_reg) - D'(q_ay_reg);
        d_acx      <= D'(q_ax_reg) - D'(s_cx);
        d_acy      <= D'(q_ay_reg) - D'(s_cy);
        d_dcx      <= D'(s_dx) - D'(s_cx);
        d_dcy      <= D'(s_dy) - D'(s_cy);
        d_bcx      <= D'(q_bx_reg) - D'(s_cx);
        d_bcy      <= D'(q_by_reg) - D'(s_cy);
        box1_reg   <= !box_fail;
        skip1_reg  <= skip_c;
        inbox1_reg <= in_box_c;
    end

    // stage 2: cross-product terms
    logic signed [P-1:0] p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg, p7_reg, p8_reg;
    logic box2_reg, skip2_reg, inbox2_reg;

    always_ff @(posedge clk)
    begin
        p1_reg     <= P'(d_cax) * P'(d_bay);
        p2_reg     <= P'(d_bax) * P'(d_cay);
        p3_reg     <= P'(d_bax) * P'(d_day);
        p4_reg     <= P'(d_dax) * P'(d_bay);
        p5_reg     <= P'(d_acx) * P'(d_dcy);
        p6_reg     <= P'(d_dcx) * P'(d_acy);
        p7_reg     <= P'(d_dcx) * P'(d_bcy);
        p8_reg     <= P'(d_bcx) * P'(d_dcy);
        box2_reg   <= box1_reg;
        skip2_reg  <= skip1_reg;
        inbox2_reg <= inbox1_reg;
    end

    // stage 3: signs and verdict
    logic signed [X-1:0] x1, x2, x3, x4;
    logic pos1, neg1, pos2, neg2, pos3, neg3, pos4, neg4;
    logic opp_a, opp_c, seg_hit;

    always_comb
    begin
        x1 = X'(p1_reg) - X'(p2_reg);
        x2 = X'(p3_reg) - X'(p4_reg);
        x3 = X'(p5_reg) - X'(p6_reg);
        x4 = X'(p7_reg) - X'(p8_reg);
        neg1 = x1[X-1];
        neg2 = x2[X-1];
        neg3 = x3[X-1];
        neg4 = x4[X-1];
        pos1 = !x1[X-1] && (|x1);
        pos2 = !x2[X-1] && (|x2);
        pos3 = !x3[X-1] && (|x3);
        pos4 = !x4[X-1] && (|x4);
        opp_a = (pos1 && neg2) || (neg1 && pos2);
        opp_c = (pos3 && neg4) || (neg3 && pos4);
        if (q_kind_reg == KIND_POINT)
            seg_hit = inbox2_reg;
        else
            seg_hit = !skip2_reg && box2_reg && !opp_a && !opp_c;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            acc_reg <= 1'b0;
        else if (v2_reg && seg_hit)
            acc_reg <= 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vr_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            vr_reg <= cmd.rd_en;
            v1_reg <= vr_reg;
            v2_reg <= v1_reg;
        end
    end

    // result register
    logic [RAW_W-1:0]       count_raw;
    logic                   out_valid_reg;
    logic                   out_hit_reg;
    logic [COUNT_OUT_W-1:0] out_count_reg;
    logic                   out_ovf_reg;

    assign count_raw = RAW_W'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_hit_reg   <= acc_reg;
            out_count_reg <= count_raw[COUNT_OUT_W-1:0];
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_hit   = out_hit_reg;
    assign out_count = out_count_reg;
    assign out_ovf   = out_ovf_reg;

    assign stat.empty     = (count_reg == '0);
    assign stat.addr_last = ((CNT_W'(addr_reg) + CNT_W'(1)) == count_reg);
    assign stat.pipe_busy = vr_reg || v1_reg || v2_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;

endmodule

// ===== hdl/edge_set_crossing_checker.sv =====
// Top level of the segment crossing checker.
// Usage:
//   req carries one beat per item: kind, then endpoints (ax, ay) and (bx, by).
//   Kinds: clear the table, insert a segment, crossing query that skips
//   segments sharing either endpoint, crossing query that skips segments
//   touching the first endpoint, and point-in-box query.
//   rsp returns one beat per item: hit, stored_count and overflow.
// Timing:
//   Clear, insert, unused kinds and queries on an empty table go straight to
//   the result register, and the next request is taken once the result is loaded.
//   A query against N stored segments reads one table entry per cycle through
//   a single intersection pipeline, lets the pipeline drain and then loads
//   its result; only then is a new request taken, so items never overlap.
//   The single read port of the segment table sets this pace.
// Reset empties the table at once; no sweep is needed.
// A result waits in the output register while rsp is stalled; one further
// request is taken meanwhile and its result holds until the first is taken.
module edge_set_crossing_checker import escc_pkg::*;
#(
    parameter int MAX_SEGMENTS = 256,
    parameter int COORD_BITS   = 16
)
(
    input logic        clk,
    input logic        rst_n,
    escc_in_if.sink    req,
    escc_out_if.source rsp
);

    escc_cmd_t  cmd;
    escc_stat_t stat;

    escc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_kind  (req.kind),
        .req_ready (req.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    escc_dpath #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .COORD_BITS   (COORD_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_kind   (req.kind),
        .in_ax     (req.ax),
        .in_ay     (req.ay),
        .in_bx     (req.bx),
        .in_by     (req.by),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_hit   (rsp.hit),
        .out_count (rsp.stored_count),
        .out_ovf   (rsp.overflow)
    );

endmodule

// ===== hdl/escc_checker.sv =====
// Port-level assertions for the segment crossing checker, with bind.
module escc_checker import escc_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   req_valid,
    input logic                   req_ready,
    input logic                   rsp_valid,
    input logic                   rsp_ready,
    input logic                   rsp_hit,
    input logic [COUNT_OUT_W-1:0] rsp_count,
    input logic                   rsp_overflow
);

    a_req_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request beat taken while previous item still in progress");

    a_ovf_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_overflow && rsp_hit))
        else $error("result flags both overflow and hit");

    a_rsp_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid)
        else $error("result beat withdrawn while stalled");

    a_rsp_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            ($stable(rsp_hit) && $stable(rsp_count) && $stable(rsp_overflow)))
        else $error("result payload changed while stalled");

endmodule

bind edge_set_crossing_checker escc_checker u_escc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_hit      (rsp.hit),
    .rsp_count    (rsp.stored_count),
    .rsp_overflow (rsp.overflow)
);
